/* rtl/vgacrt_pkg.sv */
// Shared types and constants for the VGA CRT timing controller.
// Holds the command codes, register indexes and port widths; no dependencies.
`default_nettype none

package vgacrt_pkg;

  localparam int NUM_REGS_DEF = 25;

  localparam int CMD_W       = 3;
  localparam int VALUE_W     = 8;
  localparam int CFG_W       = 5;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_WR_INDEX = 3'd1,
    CMD_WR_DATA  = 3'd2,
    CMD_RD_INDEX = 3'd3,
    CMD_RD_DATA  = 3'd4
  } cmd_t;

  localparam logic [7:0] REG_H_TOTAL       = 8'd0;
  localparam logic [7:0] REG_H_DISP_END    = 8'd1;
  localparam logic [7:0] REG_H_BLANK_START = 8'd2;
  localparam logic [7:0] REG_H_BLANK_END   = 8'd3;
  localparam logic [7:0] REG_H_SYNC_START  = 8'd4;
  localparam logic [7:0] REG_H_SYNC_END    = 8'd5;
  localparam logic [7:0] REG_V_TOTAL       = 8'd6;
  localparam logic [7:0] REG_OVERFLOW      = 8'd7;
  localparam logic [7:0] REG_PRESET_ROW    = 8'd8;
  localparam logic [7:0] REG_MAX_SCAN      = 8'd9;
  localparam logic [7:0] REG_START_HI      = 8'd12;
  localparam logic [7:0] REG_START_LO      = 8'd13;
  localparam logic [7:0] REG_V_SYNC_START  = 8'd16;
  localparam logic [7:0] REG_V_SYNC_END    = 8'd17;
  localparam logic [7:0] REG_V_DISP_END    = 8'd18;
  localparam logic [7:0] REG_OFFSET        = 8'd19;
  localparam logic [7:0] REG_V_BLANK_START = 8'd21;
  localparam logic [7:0] REG_V_BLANK_END   = 8'd22;
  localparam logic [7:0] REG_MODE_CTRL     = 8'd23;
  localparam logic [7:0] REG_LINE_COMPARE  = 8'd24;

  localparam logic [7:0] INVALID_INDEX = 8'hFF;

endpackage

`default_nettype wire

/* rtl/vga_crt_timing_controller_core.sv */
// Top level of the VGA CRT timing controller: register file, timing decode,
// raster counters and the output register. Depends on vgacrt_pkg.
//
//   Channel  Direction  Contents
//   s_*      in         one request: tuser = cmd, tdata = value
//   m_*      out        one result per request: counters, read byte, event flags
//   cfg_*    in         char_width register write
//
// A new request is taken every cycle while s_tready is high; its result is registered.
// The adder, multiply and compare chain of the tick path sets the clock.
// The result register sits between the sides, so s_tready stays high while a
// result waits, as long as m_tready takes it in the same cycle.
// Reset clears all state but m_tdata, the register file included, and sets char_width to 8.
`default_nettype none

module vga_crt_timing_controller_core #(
  parameter int NUM_REGS = vgacrt_pkg::NUM_REGS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output      logic                                s_tready,
  // value[7:0]
  input  wire logic [vgacrt_pkg::VALUE_W-1:0]      s_tdata,
  // cmd[2:0]
  input  wire logic [vgacrt_pkg::CMD_W-1:0]        s_tuser,
  output      logic                                m_tvalid,
  input  wire logic                                m_tready,
  // read_data[7:0], h_pos[19:8], v_pos[30:20], row_scan[36:31],
  // mem_address[52:37], end_of_row[53], new_frame[54], render_frame[55],
  // mode_changed[56], irq_pending[57], blink_slow[58], blink_fast[59], zero
  output      logic [vgacrt_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [vgacrt_pkg::CFG_W-1:0]        cfg_wdata
);

  import vgacrt_pkg::*;

  localparam int IDX_W = $clog2(NUM_REGS);

  logic [7:0]  raw_regs [NUM_REGS];
  logic [CFG_W-1:0] char_width;

  logic [7:0]  sel_index,       sel_index_next;
  logic [7:0]  h_total_chars,   h_total_chars_next;
  logic [7:0]  h_blank_begin,   h_blank_begin_next;
  logic [5:0]  h_blank_stop,    h_blank_stop_next;
  logic [9:0]  v_total_lines,   v_total_lines_next;
  logic [9:0]  v_display_end,   v_display_end_next;
  logic [9:0]  v_sync_begin,    v_sync_begin_next;
  logic [9:0]  split_line,      split_line_next;
  logic [4:0]  max_scan,        max_scan_next;
  logic        scan_double,     scan_double_next;
  logic [4:0]  preset_row,      preset_row_next;
  logic [15:0] start_addr,      start_addr_next;
  logic [7:0]  line_pitch,      line_pitch_next;
  logic        vint_enable,     vint_enable_next;
  logic [11:0] pixel_pos,       pixel_pos_next;
  logic [10:0] line_pos,        line_pos_next;
  logic [5:0]  row_counter,     row_counter_next;
  logic [15:0] line_start_addr, line_start_addr_next;
  logic [15:0] refresh_addr,    refresh_addr_next;
  logic        doubled_flag,    doubled_flag_next;
  logic [3:0]  frame_count,     frame_count_next;
  logic        timing_dirty,    timing_dirty_next;
  logic        irq_flag,        irq_flag_next;
  logic [1:0]  blink_bits,      blink_bits_next;

  logic        accept;
  cmd_t        cmd;
  logic        sel_valid;
  logic        raw_we;
  logic [7:0]  rd;
  logic        eor, nf, rf, mc;
  logic [13:0] htotal;
  logic        hb_wrap;
  logic [1:0]  hb_hi;
  logic [7:0]  hb_pos;
  logic [12:0] hblank;
  logic [11:0] pix_sum;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cmd       = cmd_t'(s_tuser);
  assign sel_valid = sel_index < 8'(NUM_REGS);
  assign raw_we    = accept && (cmd == CMD_WR_DATA) && sel_valid;

  // The blank end is the next character position after the blank start whose
  // low six bits match the stop value, kept to eight bits.
  assign hb_wrap = h_blank_begin[5:0] >= h_blank_stop;
  assign hb_hi   = h_blank_begin[7:6] + {1'b0, hb_wrap};
  assign hb_pos  = {hb_hi, h_blank_stop};
  assign hblank  = {5'b0, hb_pos} * {8'b0, char_width};
  assign htotal  = 14'({1'b0, h_total_chars} + 9'd5) * {9'b0, char_width};
  assign pix_sum = pixel_pos + {7'b0, char_width};

  always_comb begin
    sel_index_next       = sel_index;
    h_total_chars_next   = h_total_chars;
    h_blank_begin_next   = h_blank_begin;
    h_blank_stop_next    = h_blank_stop;
    v_total_lines_next   = v_total_lines;
    v_display_end_next   = v_display_end;
    v_sync_begin_next    = v_sync_begin;
    split_line_next      = split_line;
    max_scan_next        = max_scan;
    scan_double_next     = scan_double;
    preset_row_next      = preset_row;
    start_addr_next      = start_addr;
    line_pitch_next      = line_pitch;
    vint_enable_next     = vint_enable;
    pixel_pos_next       = pixel_pos;
    line_pos_next        = line_pos;
    row_counter_next     = row_counter;
    line_start_addr_next = line_start_addr;
    refresh_addr_next    = refresh_addr;
    doubled_flag_next    = doubled_flag;
    frame_count_next     = frame_count;
    timing_dirty_next    = timing_dirty;
    irq_flag_next        = irq_flag;
    blink_bits_next      = blink_bits;
    rd  = 8'd0;
    eor = 1'b0;
    nf  = 1'b0;
    rf  = 1'b0;
    mc  = 1'b0;
    if (accept) begin
      unique case (cmd)
        CMD_TICK: begin
          pixel_pos_next    = pix_sum;
          refresh_addr_next = refresh_addr + 16'd1;
          eor = {1'b0, pix_sum} == hblank;
          if ({2'b0, pix_sum} >= htotal) begin
            pixel_pos_next = 12'd0;
            line_pos_next  = line_pos + 11'd1;
            if (scan_double && !doubled_flag) begin
              doubled_flag_next = 1'b1;
            end else begin
              doubled_flag_next = 1'b0;
              row_counter_next  = row_counter + 6'd1;
            end
            if (row_counter_next > {1'b0, max_scan}) begin
              row_counter_next     = 6'd0;
              line_start_addr_next = line_start_addr + {7'b0, line_pitch, 1'b0};
            end
            if (line_pos_next == {1'b0, split_line}) begin
              line_start_addr_next = 16'd0;
              row_counter_next     = 6'd0;
            end
            refresh_addr_next = line_start_addr_next;
            if (vint_enable && line_pos_next == ({1'b0, v_display_end} + 11'd1)) begin
              irq_flag_next = 1'b1;
            end
            nf = line_pos_next == {1'b0, v_sync_begin};
            if (line_pos_next >= ({1'b0, v_total_lines} + 11'd2)) begin
              rf = 1'b1;
              frame_count_next     = frame_count + 4'd1;
              doubled_flag_next    = 1'b0;
              line_pos_next        = 11'd0;
              row_counter_next     = {1'b0, preset_row};
              line_start_addr_next = start_addr;
              refresh_addr_next    = start_addr;
              if (timing_dirty) begin
                timing_dirty_next = 1'b0;
                mc = 1'b1;
              end
              if (frame_count_next[2:0] == 3'd0) begin
                blink_bits_next[0] = ~blink_bits[0];
              end
              if (frame_count_next == 4'd0) begin
                blink_bits_next[1] = ~blink_bits[1];
              end
            end
          end
        end
        CMD_WR_INDEX: begin
          if ({3'b0, s_tdata[4:0]} > 8'(NUM_REGS - 1)) begin
            sel_index_next = INVALID_INDEX;
          end else begin
            sel_index_next = {3'b0, s_tdata[4:0]};
          end
        end
        CMD_WR_DATA: begin
          unique case (sel_index) inside
            REG_H_TOTAL: begin
              h_total_chars_next = s_tdata;
              timing_dirty_next  = 1'b1;
            end
            REG_H_BLANK_START: begin
              h_blank_begin_next = s_tdata;
              timing_dirty_next  = 1'b1;
            end
            REG_H_BLANK_END: begin
              // A write here also clears the high bit held from the sync end register.
              h_blank_stop_next = {1'b0, s_tdata[4:0]};
              timing_dirty_next = 1'b1;
            end
            REG_H_SYNC_END: begin
              h_blank_stop_next = {s_tdata[7], h_blank_stop[4:0]};
              timing_dirty_next = 1'b1;
            end
            REG_V_TOTAL: begin
              v_total_lines_next = {v_total_lines[9:8], s_tdata};
              timing_dirty_next  = 1'b1;
            end
            REG_OVERFLOW: begin
              v_total_lines_next = {s_tdata[5], s_tdata[0], v_total_lines[7:0]};
              v_display_end_next = {s_tdata[6], s_tdata[1], v_display_end[7:0]};
              v_sync_begin_next  = {s_tdata[7], s_tdata[2], v_sync_begin[7:0]};
              split_line_next    = {split_line[9], s_tdata[4], split_line[7:0]};
              timing_dirty_next  = 1'b1;
            end
            REG_PRESET_ROW: begin
              preset_row_next   = s_tdata[4:0];
              timing_dirty_next = 1'b1;
            end
            REG_MAX_SCAN: begin
              max_scan_next     = s_tdata[4:0];
              split_line_next   = {s_tdata[6], split_line[8:0]};
              scan_double_next  = s_tdata[7];
              timing_dirty_next = 1'b1;
            end
            REG_START_HI: begin
              start_addr_next = {s_tdata, start_addr[7:0]};
            end
            REG_START_LO: begin
              start_addr_next = {start_addr[15:8], s_tdata};
            end
            REG_V_SYNC_START: begin
              v_sync_begin_next = {v_sync_begin[9:8], s_tdata};
              timing_dirty_next = 1'b1;
            end
            REG_V_SYNC_END: begin
              if (!s_tdata[4]) begin
                irq_flag_next = 1'b0;
              end
              vint_enable_next  = ~s_tdata[5];
              timing_dirty_next = 1'b1;
            end
            REG_V_DISP_END: begin
              v_display_end_next = {v_display_end[9:8], s_tdata};
              timing_dirty_next  = 1'b1;
            end
            REG_OFFSET: begin
              line_pitch_next   = s_tdata;
              timing_dirty_next = 1'b1;
            end
            REG_LINE_COMPARE: begin
              split_line_next   = {split_line[9:8], s_tdata};
              timing_dirty_next = 1'b1;
            end
            REG_H_DISP_END, REG_H_SYNC_START, REG_V_BLANK_START, REG_V_BLANK_END,
            REG_MODE_CTRL: begin
              timing_dirty_next = 1'b1;
            end
            default: begin
            end
          endcase
        end
        CMD_RD_INDEX: begin
          rd = sel_index;
        end
        CMD_RD_DATA: begin
          rd = sel_valid ? raw_regs[sel_index[IDX_W-1:0]] : INVALID_INDEX;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        raw_regs[i] <= 8'd0;
      end
    end else if (raw_we) begin
      raw_regs[sel_index[IDX_W-1:0]] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_width <= CFG_W'(8);
    end else if (cfg_we) begin
      char_width <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_index       <= 8'd0;
      h_total_chars   <= 8'd0;
      h_blank_begin   <= 8'd0;
      h_blank_stop    <= 6'd0;
      v_total_lines   <= 10'd0;
      v_display_end   <= 10'd0;
      v_sync_begin    <= 10'd0;
      split_line      <= 10'd0;
      max_scan        <= 5'd0;
      scan_double     <= 1'b0;
      preset_row      <= 5'd0;
      start_addr      <= 16'd0;
      line_pitch      <= 8'd0;
      vint_enable     <= 1'b0;
      pixel_pos       <= 12'd0;
      line_pos        <= 11'd0;
      row_counter     <= 6'd0;
      line_start_addr <= 16'd0;
      refresh_addr    <= 16'd0;
      doubled_flag    <= 1'b0;
      frame_count     <= 4'd0;
      timing_dirty    <= 1'b0;
      irq_flag        <= 1'b0;
      blink_bits      <= 2'd0;
    end else begin
      sel_index       <= sel_index_next;
      h_total_chars   <= h_total_chars_next;
      h_blank_begin   <= h_blank_begin_next;
      h_blank_stop    <= h_blank_stop_next;
      v_total_lines   <= v_total_lines_next;
      v_display_end   <= v_display_end_next;
      v_sync_begin    <= v_sync_begin_next;
      split_line      <= split_line_next;
      max_scan        <= max_scan_next;
      scan_double     <= scan_double_next;
      preset_row      <= preset_row_next;
      start_addr      <= start_addr_next;
      line_pitch      <= line_pitch_next;
      vint_enable     <= vint_enable_next;
      pixel_pos       <= pixel_pos_next;
      line_pos        <= line_pos_next;
      row_counter     <= row_counter_next;
      line_start_addr <= line_start_addr_next;
      refresh_addr    <= refresh_addr_next;
      doubled_flag    <= doubled_flag_next;
      frame_count     <= frame_count_next;
      timing_dirty    <= timing_dirty_next;
      irq_flag        <= irq_flag_next;
      blink_bits      <= blink_bits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {4'b0, blink_bits_next[0], blink_bits_next[1], irq_flag_next, mc, rf, nf,
                  eor, refresh_addr_next, row_counter_next, line_pos_next, pixel_pos_next,
                  rd};
    end
  end

endmodule

`default_nettype wire

/* verif/vga_crt_timing_checker.sv */
`timescale 1ns / 100ps
// Result checker for the VGA CRT timing controller: watches the request, result and
// char_width channels, predicts every result and compares it field by field.
// Depends on vgacrt_pkg for the command codes, register indexes and port widths.

module vga_crt_timing_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  input  wire logic                                s_tready,
  input  wire logic [vgacrt_pkg::VALUE_W-1:0]      s_tdata,
  input  wire logic [vgacrt_pkg::CMD_W-1:0]        s_tuser,
  input  wire logic                                m_tvalid,
  input  wire logic                                m_tready,
  input  wire logic [vgacrt_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [vgacrt_pkg::CFG_W-1:0]        cfg_wdata,
  output int                                       failures,
  output int                                       pending,
  output int                                       checked,
  output int                                       frames
);
  import vgacrt_pkg::*;

  localparam logic [7:0] NO_REG_DATA = 8'hFF;

  typedef struct packed {
    logic [3:0]  padding;
    logic        blink_fast;
    logic        blink_slow;
    logic        irq_pending;
    logic        mode_changed;
    logic        render_frame;
    logic        new_frame;
    logic        end_of_row;
    logic [15:0] mem_address;
    logic [5:0]  row_scan;
    logic [10:0] v_pos;
    logic [11:0] h_pos;
    logic [7:0]  read_data;
  } crt_result_t;

  crt_result_t crt_expected [$];

  logic [4:0]  char_w;
  logic [7:0]  regfile [NUM_REGS_DEF];
  logic [7:0]  index_sel;
  logic [7:0]  htot_chars;
  logic [7:0]  hblank_start;
  logic [5:0]  hblank_end6;
  logic [9:0]  vtot;
  logic [9:0]  vdisp_end;
  logic [9:0]  vsync_start;
  logic [9:0]  line_cmp;
  logic [4:0]  max_row;
  logic        dbl_scan;
  logic [4:0]  row_preset;
  logic [15:0] disp_start;
  logic [7:0]  pitch_words;
  logic        vint_on;
  logic [11:0] pix;
  logic [10:0] line;
  logic [5:0]  row;
  logic [15:0] row_base;
  logic [15:0] scan_addr;
  logic        dbl_phase;
  logic [3:0]  frame_ctr;
  logic        regs_touched;
  logic        vint_flag;
  logic [1:0]  blink;

  task automatic predict_request(input logic [CMD_W-1:0] cmd, input logic [7:0] value,
                                 output crt_result_t res);
    int unsigned line_len;
    int unsigned blank_pos;
    int unsigned mark;
    res = '0;
    case (cmd)
      CMD_TICK: begin
        line_len = (htot_chars + 32'd5) * char_w;
        mark = hblank_start;
        if ((mark & 32'h3F) >= hblank_end6) mark = (mark | 32'h3F) + 32'd1;
        mark = (mark & ~32'h3F) | hblank_end6;
        blank_pos = (mark & 32'hFF) * char_w;
        pix = pix + 12'(char_w);
        scan_addr = scan_addr + 16'd1;
        if (pix == blank_pos) res.end_of_row = 1'b1;
        if (pix >= line_len) begin
          pix = '0;
          line = line + 11'd1;
          if (dbl_scan && !dbl_phase) begin
            dbl_phase = 1'b1;
          end else begin
            dbl_phase = 1'b0;
            row = row + 6'd1;
          end
          if (row > max_row) begin
            row = '0;
            row_base = row_base + {7'd0, pitch_words, 1'b0};
          end
          if (line == line_cmp) begin
            row_base = '0;
            row = '0;
          end
          scan_addr = row_base;
          if (vint_on && line == vdisp_end + 32'd1) vint_flag = 1'b1;
          if (line == vsync_start) res.new_frame = 1'b1;
          if (line >= vtot + 32'd2) begin
            res.render_frame = 1'b1;
            frame_ctr = frame_ctr + 4'd1;
            dbl_phase = 1'b0;
            line = '0;
            row = {1'b0, row_preset};
            row_base = disp_start;
            scan_addr = disp_start;
            if (regs_touched) begin
              regs_touched = 1'b0;
              res.mode_changed = 1'b1;
            end
            if (frame_ctr[2:0] == 3'd0) blink[0] = ~blink[0];
            if (frame_ctr == 4'd0) blink[1] = ~blink[1];
          end
        end
      end
      CMD_WR_INDEX: begin
        index_sel = (value[4:0] >= NUM_REGS_DEF) ? INVALID_INDEX : {3'd0, value[4:0]};
      end
      CMD_WR_DATA: begin
        if (index_sel < NUM_REGS_DEF) begin
          regfile[index_sel] = value;
          case (index_sel)
            REG_H_TOTAL: begin
              htot_chars = value;
              regs_touched = 1'b1;
            end
            REG_H_BLANK_START: begin
              hblank_start = value;
              regs_touched = 1'b1;
            end
            REG_H_BLANK_END: begin
              hblank_end6 = {1'b0, value[4:0]};
              regs_touched = 1'b1;
            end
            REG_H_SYNC_END: begin
              hblank_end6[5] = value[7];
              regs_touched = 1'b1;
            end
            REG_V_TOTAL: begin
              vtot[7:0] = value;
              regs_touched = 1'b1;
            end
            REG_OVERFLOW: begin
              vtot[9:8] = {value[5], value[0]};
              vdisp_end[9:8] = {value[6], value[1]};
              vsync_start[9:8] = {value[7], value[2]};
              line_cmp[8] = value[4];
              regs_touched = 1'b1;
            end
            REG_PRESET_ROW: begin
              row_preset = value[4:0];
              regs_touched = 1'b1;
            end
            REG_MAX_SCAN: begin
              max_row = value[4:0];
              line_cmp[9] = value[6];
              dbl_scan = value[7];
              regs_touched = 1'b1;
            end
            REG_START_HI: disp_start[15:8] = value;
            REG_START_LO: disp_start[7:0] = value;
            REG_V_SYNC_START: begin
              vsync_start[7:0] = value;
              regs_touched = 1'b1;
            end
            REG_V_SYNC_END: begin
              if (!value[4]) vint_flag = 1'b0;
              vint_on = ~value[5];
              regs_touched = 1'b1;
            end
            REG_V_DISP_END: begin
              vdisp_end[7:0] = value;
              regs_touched = 1'b1;
            end
            REG_OFFSET: begin
              pitch_words = value;
              regs_touched = 1'b1;
            end
            REG_H_DISP_END, REG_H_SYNC_START, REG_V_BLANK_START, REG_V_BLANK_END,
            REG_MODE_CTRL: regs_touched = 1'b1;
            REG_LINE_COMPARE: begin
              line_cmp[7:0] = value;
              regs_touched = 1'b1;
            end
            default: ;
          endcase
        end
      end
      CMD_RD_INDEX: res.read_data = index_sel;
      CMD_RD_DATA: res.read_data = (index_sel < NUM_REGS_DEF) ? regfile[index_sel] : NO_REG_DATA;
      default: ;
    endcase
    res.h_pos = pix;
    res.v_pos = line;
    res.row_scan = row;
    res.mem_address = scan_addr;
    res.irq_pending = vint_flag;
    res.blink_slow = blink[1];
    res.blink_fast = blink[0];
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : watch
    crt_result_t got;
    crt_result_t want;
    if (rst) begin
      crt_expected.delete();
      failures = 0;
      checked = 0;
      frames = 0;
      char_w = 5'd8;
      foreach (regfile[i]) regfile[i] = '0;
      index_sel = '0;
      htot_chars = '0;
      hblank_start = '0;
      hblank_end6 = '0;
      vtot = '0;
      vdisp_end = '0;
      vsync_start = '0;
      line_cmp = '0;
      max_row = '0;
      dbl_scan = 1'b0;
      row_preset = '0;
      disp_start = '0;
      pitch_words = '0;
      vint_on = 1'b0;
      pix = '0;
      line = '0;
      row = '0;
      row_base = '0;
      scan_addr = '0;
      dbl_phase = 1'b0;
      frame_ctr = '0;
      regs_touched = 1'b0;
      vint_flag = 1'b0;
      blink = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (crt_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%016h", $time, m_tdata);
          failures++;
        end else begin
          want = crt_expected.pop_front();
          compare_field("read_data", want.read_data, got.read_data);
          compare_field("h_pos", want.h_pos, got.h_pos);
          compare_field("v_pos", want.v_pos, got.v_pos);
          compare_field("row_scan", want.row_scan, got.row_scan);
          compare_field("mem_address", want.mem_address, got.mem_address);
          compare_field("end_of_row", want.end_of_row, got.end_of_row);
          compare_field("new_frame", want.new_frame, got.new_frame);
          compare_field("render_frame", want.render_frame, got.render_frame);
          compare_field("mode_changed", want.mode_changed, got.mode_changed);
          compare_field("irq_pending", want.irq_pending, got.irq_pending);
          compare_field("blink_slow", want.blink_slow, got.blink_slow);
          compare_field("blink_fast", want.blink_fast, got.blink_fast);
          compare_field("padding", want.padding, got.padding);
          checked++;
          if (want.render_frame) frames++;
        end
      end
      if (s_tvalid && s_tready) begin
        predict_request(s_tuser, s_tdata, want);
        crt_expected.push_back(want);
      end
      if (cfg_we) char_w = cfg_wdata;
    end
    pending <= crt_expected.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// Top of the VGA CRT timing controller testbench: clock, reset and request stimulus,
// the char_width settings and the verdict. Depends on vgacrt_pkg, the core and the checker.

module tb;
  import vgacrt_pkg::*;

  localparam logic [7:0] REG_CURSOR_START = 8'd10;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [VALUE_W-1:0]      s_tdata = '0;
  logic [CMD_W-1:0]        s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic                    cfg_we = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  bit steady = 1'b0;
  int requests_sent = 0;
  int failures;
  int pending;
  int checked;
  int frames;

  always #5 clk = ~clk;

  vga_crt_timing_controller_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  vga_crt_timing_checker crt_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .pending   (pending),
    .checked   (checked),
    .frames    (frames)
  );

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 16);
  end

  // Valid stays high from one request to the next unless a gap is inserted.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [7:0] value);
    while (!steady && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain_results();
    int guard;
    s_tvalid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (2) @(posedge clk);
  endtask

  // Keeps the timing small enough that lines and frames come around often.
  function automatic logic [7:0] tame_value(input logic [7:0] idx, input bit wild);
    logic [7:0] v;
    v = 8'($urandom);
    if (!wild) begin
      case (idx)
        REG_H_TOTAL: v = 8'($urandom_range(0, 6));
        REG_H_BLANK_START: v = 8'($urandom_range(0, 12));
        REG_V_TOTAL: v = 8'($urandom_range(0, 12));
        REG_OVERFLOW: v = v & 8'h08;
        REG_MAX_SCAN: v = v & 8'hBF;
        REG_V_SYNC_START, REG_V_DISP_END, REG_LINE_COMPARE: v = 8'($urandom_range(0, 14));
        REG_V_SYNC_END: v[5] = ($urandom_range(3) == 0);
        default: ;
      endcase
    end
    return v;
  endfunction

  initial begin
    logic [7:0] timing_regs [15];
    logic [7:0] reg_sel;
    logic [CMD_W-1:0] noise_cmd;
    logic [CFG_W-1:0] next_width;
    int issued;
    int pick;
    int run;

    timing_regs = '{REG_H_TOTAL, REG_H_BLANK_START, REG_H_BLANK_END, REG_H_SYNC_END,
                    REG_V_TOTAL, REG_OVERFLOW, REG_PRESET_ROW, REG_MAX_SCAN, REG_START_HI,
                    REG_START_LO, REG_V_SYNC_START, REG_V_SYNC_END, REG_V_DISP_END,
                    REG_OFFSET, REG_LINE_COMPARE};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests: reads of the reset state, an index past the register file,
    // unknown commands, the blank-end bit 5 quirk and a start address at the top.
    send_request(CMD_RD_INDEX, 8'h00);
    send_request(CMD_RD_DATA, 8'h00);
    send_request(CMD_WR_INDEX, 8'hFF);
    send_request(CMD_RD_INDEX, 8'h00);
    send_request(CMD_WR_DATA, 8'hAA);
    send_request(CMD_RD_DATA, 8'h00);
    for (int c = CMD_RD_DATA + 1; c < 8; c++) send_request(CMD_W'(c), 8'hFF);
    send_request(CMD_WR_INDEX, 8'hE0 | REG_LINE_COMPARE);
    send_request(CMD_WR_DATA, 8'hFF);
    send_request(CMD_WR_INDEX, REG_H_BLANK_END);
    send_request(CMD_WR_DATA, 8'hFF);
    send_request(CMD_WR_INDEX, REG_H_SYNC_END);
    send_request(CMD_WR_DATA, 8'h80);
    send_request(CMD_WR_INDEX, REG_H_BLANK_END);
    send_request(CMD_WR_DATA, 8'h3F);
    send_request(CMD_WR_INDEX, REG_START_HI);
    send_request(CMD_WR_DATA, 8'hFF);
    send_request(CMD_WR_INDEX, REG_START_LO);
    send_request(CMD_WR_DATA, 8'hFE);
    send_request(CMD_WR_INDEX, REG_V_SYNC_END);
    send_request(CMD_WR_DATA, 8'h00);
    send_request(CMD_WR_INDEX, REG_CURSOR_START);
    send_request(CMD_WR_DATA, 8'h55);
    send_request(CMD_RD_DATA, 8'h00);
    repeat (12) send_request(CMD_TICK, 8'($urandom));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: next_width = 5'd8;
        1: next_width = 5'd9;
        2: next_width = 5'd1;
        3: next_width = 5'd16;
        4: next_width = 5'd0;
        5: next_width = 5'd31;
        6: next_width = CFG_W'($urandom_range(1, 16));
        default: next_width = 5'd8;
      endcase
      drain_results();
      cfg_we <= 1'b1;
      cfg_wdata <= next_width;
      @(posedge clk);
      cfg_we <= 1'b0;
      steady = (ph == 2);

      foreach (timing_regs[i]) begin
        send_request(CMD_WR_INDEX, timing_regs[i]);
        send_request(CMD_WR_DATA, tame_value(timing_regs[i], 1'b0));
      end

      // A line longer than the pixel counter range lets the counter wrap.
      if (next_width == 5'd31) begin
        send_request(CMD_WR_INDEX, REG_H_TOTAL);
        send_request(CMD_WR_DATA, 8'hFF);
        repeat (140) send_request(CMD_TICK, 8'($urandom));
        send_request(CMD_WR_INDEX, REG_H_TOTAL);
        send_request(CMD_WR_DATA, tame_value(REG_H_TOTAL, 1'b0));
      end

      issued = 0;
      while (issued < 100) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          run = $urandom_range(1, 32);
          repeat (run) send_request(CMD_TICK, 8'($urandom));
          issued += run;
        end else if (pick < 95) begin
          reg_sel = 8'($urandom);
          send_request(CMD_WR_INDEX, reg_sel);
          send_request(CMD_WR_DATA, tame_value({3'd0, reg_sel[4:0]}, $urandom_range(9) == 0));
          if ($urandom_range(1) == 1) send_request(CMD_RD_DATA, 8'($urandom));
          if ($urandom_range(3) == 0) send_request(CMD_RD_INDEX, 8'($urandom));
          issued += 2;
        end else begin
          noise_cmd = CMD_W'($urandom_range(1, 7));
          send_request(noise_cmd, 8'($urandom));
          if (noise_cmd <= CMD_RD_DATA) issued++;
        end
      end
    end

    drain_results();
    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    $display("Drove %0d requests over eight char_width settings and compared %0d results.",
             requests_sent, checked);
    $display("The raster counters completed %0d frames during the run.", frames);
    if (failures == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: run timed out with %0d results outstanding", $time, pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
